### rtl/core/bpg_pkg.sv
package bpg_pkg;

  // Fast ticks per slow tick of the period counter
  localparam int unsigned PRESCALE = 32;
  localparam int unsigned PS_W = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;
  localparam logic [PS_W-1:0] PS_LAST = PS_W'(PRESCALE - 1);

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned ON_W     = 10;
  localparam int unsigned BURST_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = PERIOD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_ON        = 2'd1,
    CFG_BURST_ON  = 2'd2,
    CFG_BURST_OFF = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period_ticks;
    logic [ON_W-1:0]     on_ticks;
    logic [BURST_W-1:0]  burst_on;
    logic [BURST_W-1:0]  burst_off;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    period_ticks: {PERIOD_W{1'b1}},
    on_ticks:     {ON_W{1'b1}},
    burst_on:     '0,
    burst_off:    '0
  };

  typedef struct packed {
    logic active;
    logic drive;
  } os_status_t;

endpackage

### rtl/core/bpg_timebase.sv
module bpg_timebase
  import bpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                enable,
  input  logic [PERIOD_W-1:0] period_ticks,
  output logic                event_o
);

  logic [PS_W-1:0]     prescale_r, prescale_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic                enable_prev_r;
  logic                ev;

  always_comb begin
    prescale_nxt = prescale_r;
    period_nxt   = period_r;
    ev           = 1'b0;
    if (enable) begin
      if (prescale_r == PS_LAST) begin
        prescale_nxt = '0;
        // a lowered period fires on the next slow tick
        if (period_r >= period_ticks) begin
          period_nxt = '0;
          ev         = 1'b1;
        end else begin
          period_nxt = period_r + 1'b1;
        end
      end else begin
        prescale_nxt = prescale_r + 1'b1;
      end
      // rising enable: restart the period, merge with any overflow
      if (!enable_prev_r) begin
        period_nxt = '0;
        ev         = 1'b1;
      end
    end
  end

  assign event_o = ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r    <= '0;
      period_r      <= '0;
      enable_prev_r <= 1'b0;
    end else if (advance) begin
      prescale_r    <= prescale_nxt;
      period_r      <= period_nxt;
      enable_prev_r <= enable;
    end
  end

endmodule

### rtl/core/bpg_oneshot.sv
module bpg_oneshot
  import bpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic       event_i,
  input  cfg_t       cfg,
  output logic       drive_nxt_o,
  output os_status_t status
);

  logic [ON_W-1:0]    on_count_r, on_count_nxt;
  logic               on_active_r, on_active_nxt;
  logic [BURST_W-1:0] pulses_r, pulses_nxt;
  logic [BURST_W-1:0] gaps_r, gaps_nxt;
  logic               drive_r, drive_nxt;

  always_comb begin
    on_count_nxt  = on_count_r;
    on_active_nxt = on_active_r;
    pulses_nxt    = pulses_r;
    gaps_nxt      = gaps_r;
    drive_nxt     = drive_r;

    // advance the running one-shot first
    if (on_active_r) begin
      if (on_count_r >= cfg.on_ticks) begin
        on_active_nxt = 1'b0;
        on_count_nxt  = '0;
        drive_nxt     = 1'b0;
      end else begin
        on_count_nxt = on_count_r + 1'b1;
      end
    end

    if (event_i) begin
      on_count_nxt  = '0;
      on_active_nxt = 1'b1;
      priority if (cfg.burst_off == '0) begin
        drive_nxt = 1'b1;
      end else if (pulses_r != '0) begin
        drive_nxt  = 1'b1;
        pulses_nxt = pulses_r - 1'b1;
      end else if (gaps_r != '0) begin
        gaps_nxt = gaps_r - 1'b1;
      end else begin
        // dark event: reload the burst
        pulses_nxt = cfg.burst_on;
        gaps_nxt   = cfg.burst_off;
      end
    end
  end

  assign drive_nxt_o   = drive_nxt;
  assign status.active = on_active_r;
  assign status.drive  = drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_count_r  <= '0;
      on_active_r <= 1'b0;
      pulses_r    <= '0;
      gaps_r      <= '0;
      drive_r     <= 1'b0;
    end else if (advance) begin
      on_count_r  <= on_count_nxt;
      on_active_r <= on_active_nxt;
      pulses_r    <= pulses_nxt;
      gaps_r      <= gaps_nxt;
      drive_r     <= drive_nxt;
    end
  end

endmodule

### rtl/core/burst_pulse_generator_unit.sv
// Burst pulse generator.
// Input channel (in_valid/in_ready/in_enable): each transaction is one fast
// timer tick carrying the enable level. Result channel (out_valid/out_ready)
// returns one transaction per tick: out_drive is the pin level after the
// tick, out_period_event flags a period or enable-edge event on that tick.
// Configuration (cfg_we/cfg_index/cfg_wdata) writes period, on time and
// burst counts; write only while no transaction is in flight.
// out_valid rises in the cycle after input acceptance. Throughput is one
// tick per cycle while results are taken: timer and one-shot state update
// in the same cycle the tick is accepted, and the result lands in a single
// output register. When the receiver stalls, the result register holds
// and in_ready drops; it rises again in the cycle the result is taken, so
// no cycle is lost. Reset (rst_n low, synchronous) clears all counters and
// out_valid and loads period 65535, on time 1023 and bursting off.
module burst_pulse_generator_unit
  import bpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_enable,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_drive,
  output logic                  out_period_event,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       accept;
  logic       ev;
  logic       drive_nxt;
  os_status_t os_status;
  logic       out_valid_r;
  logic       out_drive_r;
  logic       out_event_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PERIOD:    cfg_r.period_ticks <= cfg_wdata[PERIOD_W-1:0];
        CFG_ON:        cfg_r.on_ticks     <= cfg_wdata[ON_W-1:0];
        CFG_BURST_ON:  cfg_r.burst_on     <= cfg_wdata[BURST_W-1:0];
        CFG_BURST_OFF: cfg_r.burst_off    <= cfg_wdata[BURST_W-1:0];
      endcase
    end
  end

  bpg_timebase u_timebase (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (accept),
    .enable       (in_enable),
    .period_ticks (cfg_r.period_ticks),
    .event_o      (ev)
  );

  bpg_oneshot u_oneshot (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (accept),
    .event_i     (ev),
    .cfg         (cfg_r),
    .drive_nxt_o (drive_nxt),
    .status      (os_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_drive_r <= drive_nxt;
      out_event_r <= ev;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive        = out_drive_r;
  assign out_period_event = out_event_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted tick produced no result");

  a_event_drives: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev && (cfg_r.burst_off == '0) |-> drive_nxt)
    else $error("event without bursting left output low");

  a_drive_needs_oneshot: assert property (@(posedge clk) disable iff (!rst_n)
    os_status.drive |-> os_status.active)
    else $error("output high with one-shot idle");

endmodule
